[rtl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared widths, reset values, register indexes and stage types of the
// spectrum two-peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int unsigned FFT_POINTS     = 1024;
  localparam int unsigned BINS_PER_FRAME = FFT_POINTS / 2;
  localparam int unsigned BIN_W          = $clog2(BINS_PER_FRAME);

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned POWER_W    = 63;
  localparam int unsigned FREQ_W     = 25;
  localparam int unsigned HZ_W       = 16;
  localparam int unsigned WIN_W      = 10;
  localparam int unsigned THR_W      = 40;
  localparam int unsigned COUNT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam int unsigned FMUL_W = (BIN_W + HZ_W > FREQ_W) ? BIN_W + HZ_W : FREQ_W;
  localparam int unsigned WCMP_W = (BIN_W > WIN_W) ? BIN_W : WIN_W;

  localparam logic [POWER_W-1:0] POWER_MAX = '1;
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = '1;

  localparam logic [WIN_W-1:0]  WINDOW_LOW_RST  = WIN_W'(5);
  localparam logic [WIN_W-1:0]  WINDOW_HIGH_RST = WIN_W'(100);
  localparam logic [HZ_W-1:0]   HZ_PER_BIN_RST  = HZ_W'(16);
  localparam logic [FREQ_W-1:0] BAND_ONE_LO_RST = FREQ_W'(400);
  localparam logic [FREQ_W-1:0] BAND_ONE_HI_RST = FREQ_W'(500);
  localparam logic [FREQ_W-1:0] BAND_TWO_LO_RST = FREQ_W'(1150);
  localparam logic [FREQ_W-1:0] BAND_TWO_HI_RST = FREQ_W'(1500);
  localparam logic [THR_W-1:0]  STRONG_THR_RST  = THR_W'(64'd429496730);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW  = 3'd0,
    CFG_WINDOW_HIGH = 3'd1,
    CFG_HZ_PER_BIN  = 3'd2,
    CFG_BAND_ONE_LO = 3'd3,
    CFG_BAND_ONE_HI = 3'd4,
    CFG_BAND_TWO_LO = 3'd5,
    CFG_BAND_TWO_HI = 3'd6,
    CFG_STRONG_THR  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0]  window_low;
    logic [WIN_W-1:0]  window_high;
    logic [HZ_W-1:0]   hz_per_bin;
    logic [FREQ_W-1:0] band_one_low;
    logic [FREQ_W-1:0] band_one_high;
    logic [FREQ_W-1:0] band_two_low;
    logic [FREQ_W-1:0] band_two_high;
    logic [THR_W-1:0]  strong_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0]   re_sq;
    logic [SQ_W-1:0]   im_sq;
    logic [FREQ_W-1:0] freq;
    logic              in_window;
    logic              last;
  } prod_t;

  typedef struct packed {
    logic [POWER_W-1:0] best_power;
    logic [FREQ_W-1:0]  best_freq;
    logic [POWER_W-1:0] runner_power;
    logic [FREQ_W-1:0]  runner_freq;
  } peaks_t;

endpackage

`default_nettype wire

[rtl/spt_if.sv]
// ----------------------------------------------------------------------------
// spt_if
// Channel interfaces of the spectrum two-peak detector: bins in, peak
// reports out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface spt_bin_if;
  logic                                valid;
  logic                                ready;
  logic signed [spt_pkg::SAMPLE_W-1:0] bin_real;
  logic signed [spt_pkg::SAMPLE_W-1:0] bin_imag;
  logic                                frame_end;

  modport source (output valid, output bin_real, output bin_imag, output frame_end,
                  input ready);
  modport sink (input valid, input bin_real, input bin_imag, input frame_end,
                output ready);
endinterface

interface spt_peak_if;
  logic                         valid;
  logic                         ready;
  logic [spt_pkg::FREQ_W-1:0]   first_freq;
  logic [spt_pkg::POWER_W-1:0]  first_power;
  logic [spt_pkg::FREQ_W-1:0]   second_freq;
  logic [spt_pkg::POWER_W-1:0]  second_power;
  logic                         bands_match;
  logic [spt_pkg::COUNT_W-1:0]  strong_count;

  modport source (output valid, output first_freq, output first_power,
                  output second_freq, output second_power, output bands_match,
                  output strong_count, input ready);
  modport sink (input valid, input first_freq, input first_power,
                input second_freq, input second_power, input bands_match,
                input strong_count, output ready);
endinterface

interface spt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [spt_pkg::CFG_IDX_W-1:0]    index;
  logic [spt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/spt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// spt_cfg_regs
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_cfg_regs (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  spt_cfg_if.sink       cfg_i,
  output spt_pkg::cfg_t cfg_o
);

  spt_pkg::cfg_t cfg_q;
  spt_pkg::cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (spt_pkg::cfg_idx_e'(cfg_i.index))
        spt_pkg::CFG_WINDOW_LOW:  cfg_d.window_low       = cfg_i.data[spt_pkg::WIN_W-1:0];
        spt_pkg::CFG_WINDOW_HIGH: cfg_d.window_high      = cfg_i.data[spt_pkg::WIN_W-1:0];
        spt_pkg::CFG_HZ_PER_BIN:  cfg_d.hz_per_bin       = cfg_i.data[spt_pkg::HZ_W-1:0];
        spt_pkg::CFG_BAND_ONE_LO: cfg_d.band_one_low     = cfg_i.data[spt_pkg::FREQ_W-1:0];
        spt_pkg::CFG_BAND_ONE_HI: cfg_d.band_one_high    = cfg_i.data[spt_pkg::FREQ_W-1:0];
        spt_pkg::CFG_BAND_TWO_LO: cfg_d.band_two_low     = cfg_i.data[spt_pkg::FREQ_W-1:0];
        spt_pkg::CFG_BAND_TWO_HI: cfg_d.band_two_high    = cfg_i.data[spt_pkg::FREQ_W-1:0];
        spt_pkg::CFG_STRONG_THR:  cfg_d.strong_threshold = cfg_i.data[spt_pkg::THR_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low       <= spt_pkg::WINDOW_LOW_RST;
      cfg_q.window_high      <= spt_pkg::WINDOW_HIGH_RST;
      cfg_q.hz_per_bin       <= spt_pkg::HZ_PER_BIN_RST;
      cfg_q.band_one_low     <= spt_pkg::BAND_ONE_LO_RST;
      cfg_q.band_one_high    <= spt_pkg::BAND_ONE_HI_RST;
      cfg_q.band_two_low     <= spt_pkg::BAND_TWO_LO_RST;
      cfg_q.band_two_high    <= spt_pkg::BAND_TWO_HI_RST;
      cfg_q.strong_threshold <= spt_pkg::STRONG_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/spt_front.sv]
// ----------------------------------------------------------------------------
// spt_front
// Input register with bin numbering and magnitudes, then the square,
// frequency and window stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  spt_bin_if.sink        bin_i,
  input  spt_pkg::cfg_t  cfg_i,
  output logic           prod_valid_o,
  output spt_pkg::prod_t prod_o,
  input  wire logic      prod_ready_i
);

  logic [spt_pkg::BIN_W-1:0] bin_cnt_q;
  logic [spt_pkg::BIN_W-1:0] bin_cnt_d;
  logic                      valid0_q;
  logic [spt_pkg::MAG_W-1:0] re_mag_q;
  logic [spt_pkg::MAG_W-1:0] im_mag_q;
  logic [spt_pkg::BIN_W-1:0] bin_q;
  logic                      last_q;
  logic                      valid1_q;
  spt_pkg::prod_t            prod_q;
  spt_pkg::prod_t            prod_d;

  logic                         accept;
  logic                         move0;
  logic                         ready0;
  logic [spt_pkg::MAG_W-1:0]    re_raw;
  logic [spt_pkg::MAG_W-1:0]    im_raw;
  logic [spt_pkg::MAG_W-1:0]    re_mag;
  logic [spt_pkg::MAG_W-1:0]    im_mag;
  logic [spt_pkg::FMUL_W-1:0]   freq_full;

  assign ready0      = !valid1_q || prod_ready_i;
  assign move0       = valid0_q && ready0;
  assign bin_i.ready = !valid0_q || ready0;
  assign accept      = bin_i.valid && bin_i.ready;

  assign re_raw = bin_i.bin_real;
  assign im_raw = bin_i.bin_imag;
  assign re_mag = re_raw[spt_pkg::MAG_W-1] ? (~re_raw + spt_pkg::MAG_W'(1)) : re_raw;
  assign im_mag = im_raw[spt_pkg::MAG_W-1] ? (~im_raw + spt_pkg::MAG_W'(1)) : im_raw;

  always_comb begin
    bin_cnt_d = bin_cnt_q;
    if (accept) begin
      if (bin_i.frame_end || bin_cnt_q == spt_pkg::BIN_W'(spt_pkg::BINS_PER_FRAME - 1)) begin
        bin_cnt_d = '0;
      end else begin
        bin_cnt_d = bin_cnt_q + spt_pkg::BIN_W'(1);
      end
    end
  end

  assign freq_full = spt_pkg::FMUL_W'(bin_q) * spt_pkg::FMUL_W'(cfg_i.hz_per_bin);

  always_comb begin
    prod_d.re_sq     = {{(spt_pkg::SQ_W-spt_pkg::MAG_W){1'b0}}, re_mag_q}
                     * {{(spt_pkg::SQ_W-spt_pkg::MAG_W){1'b0}}, re_mag_q};
    prod_d.im_sq     = {{(spt_pkg::SQ_W-spt_pkg::MAG_W){1'b0}}, im_mag_q}
                     * {{(spt_pkg::SQ_W-spt_pkg::MAG_W){1'b0}}, im_mag_q};
    prod_d.freq      = (freq_full > spt_pkg::FMUL_W'(spt_pkg::FREQ_MAX))
                     ? spt_pkg::FREQ_MAX : freq_full[spt_pkg::FREQ_W-1:0];
    prod_d.in_window = (spt_pkg::WCMP_W'(bin_q) > spt_pkg::WCMP_W'(cfg_i.window_low))
                    && (spt_pkg::WCMP_W'(bin_q) < spt_pkg::WCMP_W'(cfg_i.window_high));
    prod_d.last      = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q <= '0;
      valid0_q  <= 1'b0;
      valid1_q  <= 1'b0;
    end else begin
      bin_cnt_q <= bin_cnt_d;
      if (bin_i.ready) begin
        valid0_q <= bin_i.valid;
      end
      if (ready0) begin
        valid1_q <= valid0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      re_mag_q <= re_mag;
      im_mag_q <= (bin_cnt_q == '0) ? '0 : im_mag;
      bin_q    <= bin_cnt_q;
      last_q   <= bin_i.frame_end;
    end
    if (move0) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = valid1_q;
  assign prod_o       = prod_q;

  a_cnt_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && bin_i.frame_end) |=> (bin_cnt_q == '0))
    else $error("bin counter not cleared after frame end");

endmodule

`default_nettype wire

[rtl/spt_tracker.sv]
// ----------------------------------------------------------------------------
// spt_tracker
// Power sum with saturation, top-two peak tracker and the end-of-frame
// snapshot register.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_tracker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       prod_valid_i,
  input  spt_pkg::prod_t  prod_i,
  output logic            prod_ready_o,
  output logic            snap_valid_o,
  output spt_pkg::peaks_t snap_o,
  input  wire logic       snap_ready_i
);

  spt_pkg::peaks_t peaks_q;
  spt_pkg::peaks_t peaks_d;
  spt_pkg::peaks_t upd;
  spt_pkg::peaks_t snap_q;
  logic            valid2_q;

  logic                       ready2;
  logic                       fire1;
  logic [spt_pkg::SQ_W-1:0]   sum;
  logic [spt_pkg::POWER_W-1:0] power;

  assign ready2       = !valid2_q || snap_ready_i;
  assign prod_ready_o = !prod_i.last || ready2;
  assign fire1        = prod_valid_i && prod_ready_o;

  assign sum   = prod_i.re_sq + prod_i.im_sq;
  assign power = sum[spt_pkg::SQ_W-1] ? spt_pkg::POWER_MAX : sum[spt_pkg::POWER_W-1:0];

  always_comb begin
    upd = peaks_q;
    if (prod_i.in_window) begin
      if (power > peaks_q.best_power) begin
        upd.runner_power = peaks_q.best_power;
        upd.runner_freq  = peaks_q.best_freq;
        upd.best_power   = power;
        upd.best_freq    = prod_i.freq;
      end else if (power > peaks_q.runner_power) begin
        upd.runner_power = power;
        upd.runner_freq  = prod_i.freq;
      end
    end
  end

  always_comb begin
    peaks_d = peaks_q;
    if (fire1) begin
      peaks_d = prod_i.last ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peaks_q  <= '0;
      valid2_q <= 1'b0;
    end else begin
      peaks_q <= peaks_d;
      if (fire1 && prod_i.last) begin
        valid2_q <= 1'b1;
      end else if (snap_ready_i) begin
        valid2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1 && prod_i.last) begin
      snap_q <= upd;
    end
  end

  assign snap_valid_o = valid2_q;
  assign snap_o       = snap_q;

  a_runner_le_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peaks_q.runner_power <= peaks_q.best_power)
    else $error("runner-up power above best power");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire1 && prod_i.last) |=> (peaks_q == '0 && valid2_q))
    else $error("tracker not cleared or snapshot missing after frame end");

endmodule

`default_nettype wire

[rtl/spt_report.sv]
// ----------------------------------------------------------------------------
// spt_report
// Band check and strength count on the frame snapshot, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_report (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  spt_pkg::cfg_t   cfg_i,
  input  wire logic       snap_valid_i,
  input  spt_pkg::peaks_t snap_i,
  output logic            snap_ready_o,
  spt_peak_if.source      peak_o
);

  logic                          valid3_q;
  logic [spt_pkg::FREQ_W-1:0]    first_freq_q;
  logic [spt_pkg::POWER_W-1:0]   first_power_q;
  logic [spt_pkg::FREQ_W-1:0]    second_freq_q;
  logic [spt_pkg::POWER_W-1:0]   second_power_q;
  logic                          bands_match_q;
  logic [spt_pkg::COUNT_W-1:0]   strong_count_q;

  logic                          take;
  logic                          band_one_ok;
  logic                          band_two_ok;
  logic                          first_strong;
  logic                          second_strong;
  logic [spt_pkg::POWER_W-1:0]   thr;

  assign snap_ready_o = !valid3_q || peak_o.ready;
  assign take         = snap_valid_i && snap_ready_o;

  assign thr           = spt_pkg::POWER_W'(cfg_i.strong_threshold);
  assign band_one_ok   = (snap_i.best_freq > cfg_i.band_one_low)
                      && (snap_i.best_freq < cfg_i.band_one_high);
  assign band_two_ok   = (snap_i.runner_freq > cfg_i.band_two_low)
                      && (snap_i.runner_freq < cfg_i.band_two_high);
  assign first_strong  = snap_i.best_power > thr;
  assign second_strong = snap_i.runner_power > thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else if (snap_ready_o) begin
      valid3_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      first_freq_q   <= snap_i.best_freq;
      first_power_q  <= snap_i.best_power;
      second_freq_q  <= snap_i.runner_freq;
      second_power_q <= snap_i.runner_power;
      bands_match_q  <= band_one_ok && band_two_ok;
      strong_count_q <= {1'b0, first_strong} + {1'b0, second_strong};
    end
  end

  assign peak_o.valid        = valid3_q;
  assign peak_o.first_freq   = first_freq_q;
  assign peak_o.first_power  = first_power_q;
  assign peak_o.second_freq  = second_freq_q;
  assign peak_o.second_power = second_power_q;
  assign peak_o.bands_match  = bands_match_q;
  assign peak_o.strong_count = strong_count_q;

endmodule

`default_nettype wire

[rtl/spectrum_two_peak_detector.sv]
// ----------------------------------------------------------------------------
// spectrum_two_peak_detector
// Top level: power spectrum search for the two strongest peaks of a frame.
// ----------------------------------------------------------------------------
// One FFT bin is taken per cycle, sustained while the output does not stall,
// with no gaps between frames; the bin number comes from an internal counter
// that restarts after each frame end and wraps after FFT_POINTS/2 bins. A frame's
// report passes the input, square and snapshot registers to the result
// register. The rate is set by the peak tracker, whose sum, compare and update
// are combinational; the squares are formed one stage earlier. The user must
// write registers only while no frame is in flight; the block does not enforce it.
`default_nettype none

module spectrum_two_peak_detector (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spt_bin_if.sink    bin_i,
  spt_peak_if.source peak_o,
  spt_cfg_if.sink    cfg_i
);

  spt_pkg::cfg_t   cfg;
  logic            prod_valid;
  logic            prod_ready;
  spt_pkg::prod_t  prod;
  logic            snap_valid;
  logic            snap_ready;
  spt_pkg::peaks_t snap;

  spt_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  spt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bin_i        (bin_i),
    .cfg_i        (cfg),
    .prod_valid_o (prod_valid),
    .prod_o       (prod),
    .prod_ready_i (prod_ready)
  );

  spt_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .prod_ready_o (prod_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  spt_report u_report (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .peak_o       (peak_o)
  );

endmodule

`default_nettype wire
